// ===== src/rgbhsv_pkg.sv =====
// Package for the 8-bit RGB to HSV converter: field widths, sector codes,
// divider geometry and the struct that rides beside the divider pipeline.
// No dependencies.
package rgbhsv_pkg;

   localparam int CH_W  = 8;   // one color channel
   localparam int HUE_W = 9;   // hue in degrees, 0..360

   // Restoring divider, instanced twice: one quotient bit per stage
   localparam int DIV_QW     = 9;
   localparam int DIV_NW     = 18;
   localparam int DIV_DW     = 9;
   localparam int DIV_STAGES = DIV_QW;

   // Sector of the maximal channel
   localparam logic [1:0] SEC_RED   = 2'd0;
   localparam logic [1:0] SEC_GREEN = 2'd1;
   localparam logic [1:0] SEC_BLUE  = 2'd2;

   localparam logic [HUE_W-1:0] HUE_BASE_RED   = 9'd0;
   localparam logic [HUE_W-1:0] HUE_BASE_GREEN = 9'd120;
   localparam logic [HUE_W-1:0] HUE_BASE_BLUE  = 9'd240;
   localparam logic [HUE_W-1:0] HUE_BASE_WRAP  = 9'd360;

   typedef struct packed {
      logic            sat_zero;
      logic            hue_zero;
      logic [CH_W-1:0] val;
   } side_type;

   // Hue offset in degrees for a sector; a red sector with falling
   // difference starts from the top of the circle.
   function automatic logic [HUE_W-1:0] hue_base(input logic [1:0] sec,
                                                 input logic       neg);
      logic [HUE_W-1:0] base;
      unique case (sec)
         SEC_RED:   base = neg ? HUE_BASE_WRAP : HUE_BASE_RED;
         SEC_GREEN: base = HUE_BASE_GREEN;
         SEC_BLUE:  base = HUE_BASE_BLUE;
         default:   base = HUE_BASE_RED;
      endcase
      return base;
   endfunction

endpackage

// ===== src/rgbhsv_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on rgbhsv_pkg for the dividend, divisor and quotient widths.
module rgbhsv_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic [rgbhsv_pkg::DIV_NW-1:0]  dividend,
   input  logic [rgbhsv_pkg::DIV_DW-1:0]  divisor,
   output logic                           out_valid,
   output logic [rgbhsv_pkg::DIV_QW-1:0]  quotient
);
   import rgbhsv_pkg::*;

   logic              vld_ff [DIV_STAGES];
   logic [DIV_NW-1:0] rem_ff [DIV_STAGES];
   logic [DIV_DW-1:0] dsr_ff [DIV_STAGES];
   logic [DIV_QW-1:0] quo_ff [DIV_STAGES];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      localparam int BIT = DIV_QW - 1 - k;

      logic              vld_src;
      logic [DIV_NW-1:0] rem_src;
      logic [DIV_DW-1:0] dsr_src;
      logic [DIV_QW-1:0] quo_src;
      logic [DIV_NW-1:0] trial;
      logic              fits;
      logic [DIV_NW-1:0] rem_in;
      logic [DIV_QW-1:0] quo_in;

      if (k == 0) begin : g_first
         assign vld_src = in_valid;
         assign rem_src = dividend;
         assign dsr_src = divisor;
         assign quo_src = '0;
      end else begin : g_next
         assign vld_src = vld_ff[k-1];
         assign rem_src = rem_ff[k-1];
         assign dsr_src = dsr_ff[k-1];
         assign quo_src = quo_ff[k-1];
      end

      // Quotient stays below 2**DIV_QW; the shifted divisor never overflows, as DIV_DW + DIV_QW - 1 <= DIV_NW
      assign trial = {{(DIV_NW-DIV_DW){1'b0}}, dsr_src} << BIT;
      assign fits  = (rem_src >= trial);

      always_comb begin
         rem_in      = fits ? (rem_src - trial) : rem_src;
         quo_in      = quo_src;
         quo_in[BIT] = fits;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_src;
         end
         rem_ff[k] <= rem_in;
         dsr_ff[k] <= dsr_src;
         quo_ff[k] <= quo_in;
      end
   end

   assign out_valid = vld_ff[DIV_STAGES-1];
   assign quotient  = quo_ff[DIV_STAGES-1];

endmodule

// ===== src/rgb_to_hsv_8bit.sv =====
// Top level of the 8-bit RGB to HSV converter: max/min, sector and
// numerator stages, then two rgbhsv_div pipelines for saturation and hue.
// Depends on rgbhsv_pkg and rgbhsv_div.
//
//   channel   direction  handshake          payload
//   request   in         start / busy       req_red_in, req_green_in, req_blue_in
//   response  out        rsp_valid strobe   rsp_hue_deg, rsp_sat_out, rsp_val_out
//
// One pixel enters per clock while busy is low; each result passes three
// front stages, nine divider stages (one quotient bit each) and one
// output register. busy follows reset and is otherwise low.
// Synchronous reset clears all valid bits and drops in-flight transactions.
// The receiver takes every strobe, so nothing stalls.
module rgb_to_hsv_8bit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [rgbhsv_pkg::CH_W-1:0]    req_red_in,
   input  logic [rgbhsv_pkg::CH_W-1:0]    req_green_in,
   input  logic [rgbhsv_pkg::CH_W-1:0]    req_blue_in,
   output logic                           rsp_valid,
   output logic [rgbhsv_pkg::HUE_W-1:0]   rsp_hue_deg,
   output logic [rgbhsv_pkg::CH_W-1:0]    rsp_sat_out,
   output logic [rgbhsv_pkg::CH_W-1:0]    rsp_val_out
);
   import rgbhsv_pkg::*;

   localparam int LATENCY = 3 + DIV_STAGES + 1;

   logic accept;
   assign busy   = reset;
   assign accept = start & ~busy;

   // Stage 1: max, min, sector, difference magnitude
   logic            r_ge_g, r_ge_b, g_ge_b;
   logic [CH_W-1:0] hi_in, lo_in, opa, opb, mag_in;
   logic [1:0]      sec_in;
   logic            neg_in;

   logic            s1_vld_ff;
   logic [CH_W-1:0] s1_hi_ff, s1_lo_ff, s1_mag_ff;
   logic [1:0]      s1_sec_ff;
   logic            s1_neg_ff;

   always_comb begin
      r_ge_g = (req_red_in >= req_green_in);
      r_ge_b = (req_red_in >= req_blue_in);
      g_ge_b = (req_green_in >= req_blue_in);
      hi_in  = r_ge_g ? (r_ge_b ? req_red_in : req_blue_in)
                      : (g_ge_b ? req_green_in : req_blue_in);
      lo_in  = r_ge_g ? (g_ge_b ? req_blue_in : req_green_in)
                      : (r_ge_b ? req_blue_in : req_red_in);
      // Ties go to red, then green
      priority if (r_ge_g && r_ge_b) begin
         sec_in = SEC_RED;
      end else if (g_ge_b) begin
         sec_in = SEC_GREEN;
      end else begin
         sec_in = SEC_BLUE;
      end
      unique case (sec_in)
         SEC_RED: begin
            opa = req_green_in;
            opb = req_blue_in;
         end
         SEC_GREEN: begin
            opa = req_blue_in;
            opb = req_red_in;
         end
         SEC_BLUE: begin
            opa = req_red_in;
            opb = req_green_in;
         end
         default: begin
            opa = req_green_in;
            opb = req_blue_in;
         end
      endcase
      neg_in = (opa < opb);
      mag_in = neg_in ? (opb - opa) : (opa - opb);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= accept;
      end
      s1_hi_ff  <= hi_in;
      s1_lo_ff  <= lo_in;
      s1_mag_ff <= mag_in;
      s1_sec_ff <= sec_in;
      s1_neg_ff <= neg_in;
   end

   // Stage 2: delta, scaled difference, hue base
   logic             s2_vld_ff;
   logic [CH_W-1:0]  s2_hi_ff, s2_delta_ff;
   logic [13:0]      s2_mag60_ff;
   logic [HUE_W-1:0] s2_base_ff;
   logic             s2_neg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
      s2_hi_ff    <= s1_hi_ff;
      s2_delta_ff <= s1_hi_ff - s1_lo_ff;
      s2_mag60_ff <= 14'(s1_mag_ff) * 14'd60;
      s2_base_ff  <= hue_base(s1_sec_ff, s1_neg_ff);
      s2_neg_ff   <= s1_neg_ff;
   end

   // Stage 3: rounding dividends and divisors
   logic [16:0]       hue_prod, hue_num, sat_num;
   logic [DIV_NW-1:0] hue_dvd_in, sat_dvd_in;
   side_type          side_in;

   logic              s3_vld_ff;
   logic [DIV_NW-1:0] s3_hue_dvd_ff, s3_sat_dvd_ff;
   logic [DIV_DW-1:0] s3_hue_dsr_ff, s3_sat_dsr_ff;
   side_type          s3_side_ff;

   always_comb begin
      hue_prod   = 17'(s2_base_ff) * 17'(s2_delta_ff);
      hue_num    = s2_neg_ff ? (hue_prod - 17'(s2_mag60_ff))
                             : (hue_prod + 17'(s2_mag60_ff));
      sat_num    = 17'(s2_delta_ff) * 17'd255;
      // round half up: floor((2n + d) / 2d)
      hue_dvd_in = {hue_num, 1'b0} + DIV_NW'(s2_delta_ff);
      sat_dvd_in = {sat_num, 1'b0} + DIV_NW'(s2_hi_ff);
      side_in.sat_zero = (s2_hi_ff == '0);
      side_in.hue_zero = (s2_delta_ff == '0);
      side_in.val      = s2_hi_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s2_vld_ff;
      end
      s3_hue_dvd_ff <= hue_dvd_in;
      s3_sat_dvd_ff <= sat_dvd_in;
      s3_hue_dsr_ff <= {s2_delta_ff, 1'b0};
      s3_sat_dsr_ff <= {s2_hi_ff, 1'b0};
      s3_side_ff    <= side_in;
   end

   // Dividers
   logic              hue_q_vld, sat_q_vld;
   logic [DIV_QW-1:0] hue_q, sat_q;

   rgbhsv_div u_hue_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_vld_ff),
      .dividend  (s3_hue_dvd_ff),
      .divisor   (s3_hue_dsr_ff),
      .out_valid (hue_q_vld),
      .quotient  (hue_q)
   );

   rgbhsv_div u_sat_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_vld_ff),
      .dividend  (s3_sat_dvd_ff),
      .divisor   (s3_sat_dsr_ff),
      .out_valid (sat_q_vld),
      .quotient  (sat_q)
   );

   // Carry flags and value alongside the divider stages
   side_type side_ff [DIV_STAGES];

   always_ff @(posedge clock) begin
      side_ff[0] <= s3_side_ff;
      for (int i = 1; i < DIV_STAGES; i++) begin
         side_ff[i] <= side_ff[i-1];
      end
   end

   // Output register
   logic             rsp_valid_ff;
   logic [HUE_W-1:0] rsp_hue_ff;
   logic [CH_W-1:0]  rsp_sat_ff, rsp_val_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= hue_q_vld & sat_q_vld;
      end
      // Zero divisors give all-ones quotients: override them
      rsp_hue_ff <= side_ff[DIV_STAGES-1].hue_zero ? '0 : HUE_W'(hue_q);
      rsp_sat_ff <= side_ff[DIV_STAGES-1].sat_zero ? '0 : sat_q[CH_W-1:0];
      rsp_val_ff <= side_ff[DIV_STAGES-1].val;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_hue_deg = rsp_hue_ff;
   assign rsp_sat_out = rsp_sat_ff;
   assign rsp_val_out = rsp_val_ff;

   // Checks
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_valid)
      else $error("result strobe missing after fixed latency");

   a_div_align: assert property (@(posedge clock) disable iff (reset)
      hue_q_vld == sat_q_vld)
      else $error("divider pipelines out of step");

   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hue_deg <= 9'd360)
      else $error("hue above 360");

   a_grey_hue: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_sat_out == '0) |-> rsp_hue_deg == '0)
      else $error("hue nonzero for zero saturation");

   a_black_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_val_out == '0) |-> rsp_sat_out == '0)
      else $error("saturation nonzero for black pixel");

endmodule
